// ===== rtl/button_debounce_click_classifier_top_defines.svh =====
// Assertion macros shared by the button debounce click classifier RTL.
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define BDCC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bdcc assertion failed");

// Next-cycle implication, disabled while reset is active.
`define BDCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bdcc assertion failed");

`endif

// ===== rtl/bdcc_pkg.sv =====
// Shared types and constants of the button debounce click classifier.
package bdcc_pkg;

	// Configuration register indexes and widths.
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_MS = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG_MS   = 8'd1;

	// Register reset values.
	localparam logic [CFG_DATA_W-1:0] SETTLE_MS_RESET = 16'd50;
	localparam logic [CFG_DATA_W-1:0] LONG_MS_RESET   = 16'd1000;

	// Click event codes.
	localparam logic [1:0] EVT_NONE  = 2'd0;
	localparam logic [1:0] EVT_SHORT = 2'd1;
	localparam logic [1:0] EVT_LONG  = 2'd2;

	// Stream data widths, padded to whole bytes.
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;

	// One button poll.
	typedef struct packed {
		logic [31:0] now_ms;
		logic        raw_level;
	} item_t;

	// One classification result.
	typedef struct packed {
		logic       is_pressed;
		logic [1:0] click_event;
	} result_t;

	// One configuration write request.
	typedef struct packed {
		logic                   valid;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
	} cfg_wr_t;

	// Button tracking state.
	typedef struct packed {
		logic        prev_raw;
		logic [31:0] change_time;
		logic        debounced_level;
		logic [31:0] press_time;
		logic        press_open;
		logic        long_done;
	} btn_state_t;

endpackage

// ===== rtl/button_debounce_click_classifier_top.sv =====
// Top level of the button debounce click classifier.
// Accepts one button poll per clock cycle while the result stream does not stall and
// returns exactly one result per poll, taken through the input register and then the
// result register. The debounce compare, hold-time compare and state update are the
// logic between these two registers, so unstalled polls run at full rate. Each result
// carries the click event (none, short click on release, long press reached once per
// press) and the debounced pressed level. After reset the button is taken as released,
// the settle time is 50 ms and the long-press time is 1000 ms; configuration writes are
// taken at any time and should be made while no poll is in flight.
module button_debounce_click_classifier_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bdcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [bdcc_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Poll stream.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [bdcc_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [0] raw_level, [32:1] now_ms
	// Result stream.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [bdcc_pkg::OUT_DATA_W-1:0]     m_axis_tdata   // [1:0] click_event, [2] is_pressed
);

	bdcc_pkg::item_t   in_item;
	bdcc_pkg::item_t   item_s1;
	bdcc_pkg::result_t core_res;
	bdcc_pkg::result_t out_res;
	bdcc_pkg::cfg_wr_t cfg;
	logic              valid_s1;
	logic              advance;
	logic              step;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// Unpack the incoming poll.
	assign in_item.raw_level = s_axis_tdata[0];
	assign in_item.now_ms    = s_axis_tdata[32:1];

	// The core works on the staged poll when the result register can take its result.
	assign step = valid_s1 && advance;

	bdcc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	bdcc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.item   (item_s1),
		.res    (core_res)
	);

	bdcc_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_res   (core_res),
		.advance    (advance),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res)
	);

	// Pack the result, padded with zeros to a whole byte.
	assign m_axis_tdata = {5'd0, out_res.is_pressed, out_res.click_event};

endmodule

// ===== rtl/bdcc_in_stage.sv =====
// Input register stage: captures one poll request and holds it until the core takes it.
module bdcc_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bdcc_pkg::item_t in_item,
	input  logic           advance,
	output logic           valid_s1,
	output bdcc_pkg::item_t item_s1
);

	// The stage takes a new request when empty or when its item moves on.
	assign in_ready = !valid_s1 || advance;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload capture.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== rtl/bdcc_core.sv =====
// Debounce and click classification logic with its state and configuration registers.
`include "button_debounce_click_classifier_top_defines.svh"

module bdcc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  bdcc_pkg::cfg_wr_t  cfg,
	input  logic               step,
	input  bdcc_pkg::item_t    item,
	output bdcc_pkg::result_t  res
);

	logic [15:0]          settle_ms_q;
	logic [15:0]          long_ms_q;
	bdcc_pkg::btn_state_t state_q;
	bdcc_pkg::btn_state_t state_nx;

	logic        raw_chg;
	logic [31:0] stable_ms;
	logic        accept;
	logic        press_acc;
	logic        rel_acc;
	logic [31:0] held_ms;
	logic [31:0] held_eff;
	logic        short_hit;
	logic        long_hit;
	logic        done_cur;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_ms_q <= bdcc_pkg::SETTLE_MS_RESET;
			long_ms_q   <= bdcc_pkg::LONG_MS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bdcc_pkg::REG_SETTLE_MS: settle_ms_q <= cfg.data;
				bdcc_pkg::REG_LONG_MS:   long_ms_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Debounce: a raw change restarts the stability time, so it never settles on that poll.
	always_comb begin
		raw_chg   = item.raw_level != state_q.prev_raw;
		stable_ms = item.now_ms - state_q.change_time;
		accept    = !raw_chg && (stable_ms > {16'd0, settle_ms_q})
			&& (item.raw_level != state_q.debounced_level);
		press_acc = accept && !item.raw_level;
		rel_acc   = accept && item.raw_level;
	end

	// Hold timing and click classification.
	always_comb begin
		held_ms   = item.now_ms - state_q.press_time;
		short_hit = rel_acc && state_q.press_open && !state_q.long_done
			&& (held_ms < {16'd0, long_ms_q});

		state_nx.prev_raw        = item.raw_level;
		state_nx.change_time     = raw_chg ? item.now_ms : state_q.change_time;
		state_nx.debounced_level = accept ? item.raw_level : state_q.debounced_level;
		state_nx.press_time      = press_acc ? item.now_ms : state_q.press_time;
		state_nx.press_open      = press_acc || (state_q.press_open && !rel_acc);

		// A press accepted on this poll has zero hold time and a fresh long flag.
		done_cur = press_acc ? 1'b0 : state_q.long_done;
		held_eff = press_acc ? 32'd0 : held_ms;
		long_hit = state_nx.press_open && !done_cur && (held_eff >= {16'd0, long_ms_q});

		state_nx.long_done = done_cur || long_hit;

		if (long_hit) begin
			res.click_event = bdcc_pkg::EVT_LONG;
		end else if (short_hit) begin
			res.click_event = bdcc_pkg::EVT_SHORT;
		end else begin
			res.click_event = bdcc_pkg::EVT_NONE;
		end
		res.is_pressed = !state_nx.debounced_level;
	end

	// Button state, updated once per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.prev_raw        <= 1'b1;
			state_q.change_time     <= 32'd0;
			state_q.debounced_level <= 1'b1;
			state_q.press_time      <= 32'd0;
			state_q.press_open      <= 1'b0;
			state_q.long_done       <= 1'b0;
		end else if (step) begin
			state_q <= state_nx;
		end
	end

	// An open press always has a pressed debounced level.
	`BDCC_ASSERT_IMPLY(a_open_pressed, clk, arst_n, state_q.press_open, !state_q.debounced_level)
	// A long click is reported while the button is held, a short one after release.
	`BDCC_ASSERT_IMPLY(a_long_held, clk, arst_n, step && (res.click_event == bdcc_pkg::EVT_LONG), res.is_pressed)
	`BDCC_ASSERT_IMPLY(a_short_rel, clk, arst_n, step && (res.click_event == bdcc_pkg::EVT_SHORT), !res.is_pressed)
	// The state moves only when a request is processed.
	`BDCC_ASSERT_NEXT(a_state_hold, clk, arst_n, !step, $stable(state_q))

endmodule

// ===== rtl/bdcc_out_reg.sv =====
// Result register on the output stream.
module bdcc_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_valid,
	input  bdcc_pkg::result_t  load_res,
	output logic               advance,
	output logic               out_valid,
	input  logic               out_ready,
	output bdcc_pkg::result_t  out_res
);

	// The register can take a new result when empty or being drained.
	assign advance = !out_valid || out_ready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= load_valid;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance && load_valid) begin
			out_res <= load_res;
		end
	end

endmodule
